FILE: hdl/hdtc_pkg.sv
`timescale 1ns / 1ps
// Package for the humidity dosing time calculator.
// Holds the coefficient bundle type, pipeline depth and the fixed-point
// reciprocal constants. Depends on nothing.
package hdtc_pkg;

  // Number of register stages from input acceptance to the output register.
  localparam int Stages = 10;

  // Reset value of the dosing multiplier, in hundredths.
  localparam logic [9:0] MultReset = 10'd100;

  // Period: floor(3*s/80) computed as (3*s*3277) >> 18, exact for 3*s <= 3600.
  localparam logic [11:0] PeriodRecip = 12'd3277;

  // Pump: the product is divided by 8e9 = 2^12 * 1953125.
  // After the shift, floor(2^40/1953125) gives a quotient at most one low.
  localparam logic [20:0] PumpDiv   = 21'd1953125;
  localparam logic [19:0] PumpRecip = 20'd562949;

  // Nebulizer: x/2000 = (x >> 4)/125, (y*8389) >> 20 is exact for y <= 5625.
  localparam logic [13:0] NebRecip = 14'd8389;

  // Nebulizer base factor, 0.1 in units of 1/2000.
  localparam logic [10:0] NebBase = 11'd200;

  // Clamped piecewise-linear coefficients, each in its own fixed unit.
  typedef struct packed {
    logic [8:0]  kt1;  // 1/400
    logic [9:0]  kh1;  // 1/800
    logic [8:0]  kt2;  // 1/200
    logic [9:0]  kh2;  // 1/1000
    logic [8:0]  kbs;  // boost sum, 1/400
    logic [10:0] krs;  // nebulizer extras sum, 1/2000
  } coef_t;

endpackage

FILE: hdl/hdtc_coef.sv
`timescale 1ns / 1ps
// Coefficient unit: clamped piecewise-linear terms from one reading pair.
// Depends on hdtc_pkg for the coefficient bundle type.
module hdtc_coef
  import hdtc_pkg::*;
(
  input  logic [10:0] temperature_deci,
  input  logic [9:0]  humidity_milli,
  output coef_t       coef
);

  logic [8:0]  kt1;
  logic [8:0]  kt2;
  logic [9:0]  kh1;
  logic [9:0]  kh2;
  logic [7:0]  kbt;
  logic [8:0]  kbh;
  logic [9:0]  krt;
  logic [9:0]  krh;
  logic [8:0]  kbs;
  logic [10:0] krs;
  logic [6:0]  t_off;
  logic [8:0]  h_off;

  // Temperature terms.
  always_comb begin
    t_off = 7'(temperature_deci - 11'd300);
    if (temperature_deci < 11'd100) begin
      kt1 = 9'd300;
      kt2 = 9'd100;
    end else if (temperature_deci > 11'd300) begin
      kt1 = 9'd100;
      kt2 = 9'd300;
    end else begin
      kt1 = 9'(11'd400 - temperature_deci);
      kt2 = temperature_deci[8:0];
    end
    if (temperature_deci < 11'd300) begin
      kbt = 8'd100;
      krt = 10'd0;
    end else if (temperature_deci > 11'd400) begin
      kbt = 8'd200;
      krt = 10'd900;
    end else begin
      kbt = 8'(temperature_deci - 11'd200);
      krt = {3'd0, t_off} + {t_off, 3'd0};
    end
  end

  // Humidity terms.
  always_comb begin
    h_off = 9'(10'd500 - humidity_milli);
    if (humidity_milli < 10'd400) begin
      kh1 = 10'd200;
      kh2 = 10'd600;
    end else if (humidity_milli > 10'd800) begin
      kh1 = 10'd600;
      kh2 = 10'd200;
    end else begin
      kh1 = humidity_milli - 10'd200;
      kh2 = 10'd1000 - humidity_milli;
    end
    if (humidity_milli < 10'd200) begin
      kbh = 9'd300;
    end else if (humidity_milli > 10'd400) begin
      kbh = 9'd100;
    end else begin
      kbh = h_off;
    end
    if (humidity_milli < 10'd200) begin
      krh = 10'd900;
    end else if (humidity_milli > 10'd500) begin
      krh = 10'd0;
    end else begin
      krh = {1'b0, h_off} + {h_off, 1'b0};
    end
  end

  // Sums used by the pump boost and the nebulizer factor.
  assign kbs = {1'b0, kbt} + kbh;
  assign krs = {1'b0, krt} + {1'b0, krh};

  // Bundle the terms in the order of the coefficient type.
  assign coef = {kt1, kh1, kt2, kh2, kbs, krs};

endmodule

FILE: hdl/humidity_dosing_time_calculator.sv
`timescale 1ns / 1ps
// Stages 1 to 10 each hold one request, stage 10 being the output register; the stall
// enable ripples back only through full stages, so bubbles are squeezed out.
// Throughput: one request per cycle while out_ready is high.
// Reset (rst, synchronous): all stages empty, dosing multiplier set to 100.
// Depends on hdtc_pkg and hdtc_coef.
module humidity_dosing_time_calculator
  import hdtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] temperature_deci,
  input  logic [9:0]  humidity_milli,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  period_seconds,
  output logic [5:0]  pump_seconds,
  output logic [5:0]  nebulizer_seconds
);

  logic [9:0]      dosing_multiplier;
  logic [Stages-1:0] vld;
  logic [Stages:0]   en;
  coef_t           coef_in;

  // Stage registers.
  coef_t       s1_coef;
  logic [23:0] s2_pprod;
  logic [17:0] s2_a;
  logic [8:0]  s2_kbs;
  logic [10:0] s2_krs;
  logic [5:0]  s3_period;
  logic [26:0] s3_b;
  logic [10:0] s3_krs;
  logic [5:0]  s4_period;
  logic [36:0] s4_c;
  logic [10:0] s4_krs;
  logic [5:0]  s5_period;
  logic [29:0] s5_pp;
  logic [10:0] s5_krs;
  logic [5:0]  s6_period;
  logic [29:0] s6_pp;
  logic [9:0]  s6_qe;
  logic [10:0] s6_krs;
  logic [5:0]  s7_period;
  logic [9:0]  s7_qe;
  logic [21:0] s7_r;
  logic [10:0] s7_krs;
  logic [5:0]  s8_period;
  logic [5:0]  s8_pump;
  logic [10:0] s8_krs;
  logic [5:0]  s9_period;
  logic [5:0]  s9_pump;
  logic [16:0] s9_nx;
  logic [5:0]  s10_period;
  logic [5:0]  s10_pump;
  logic [5:0]  s10_neb;

  // Combinational values between stages.
  logic [10:0] s2_sum;
  logic [11:0] s2_x;
  logic [23:0] s2_pprod_next;
  logic [18:0] s2_a_next;
  logic [42:0] s5_prod;
  logic [49:0] s6_prod;
  logic [30:0] s7_qd;
  logic [29:0] s7_diff;
  logic [10:0] s8_q;
  logic [10:0] s9_factor;
  logic [25:0] s10_prod;

  hdtc_coef u_coef (
    .temperature_deci (temperature_deci),
    .humidity_milli   (humidity_milli),
    .coef             (coef_in)
  );

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dosing_multiplier <= MultReset;
    end else if (cfg_valid) begin
      dosing_multiplier <= cfg_data;
    end
  end

  // A stage loads when it is empty or when its contents move on.
  always_comb begin
    en[Stages] = out_ready;
    for (int i = Stages - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[Stages-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: coefficients.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_coef <= coef_in;
    end
  end

  // Stage 2: period numerator times reciprocal, and KT2 times KH2.
  assign s2_sum        = {1'b0, s1_coef.kt1, 1'b0} + {1'b0, s1_coef.kh1};
  assign s2_x          = {1'b0, s2_sum} + {s2_sum, 1'b0};
  assign s2_pprod_next = s2_x * PeriodRecip;
  assign s2_a_next     = s1_coef.kt2 * s1_coef.kh2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_pprod <= s2_pprod_next;
      s2_a     <= s2_a_next[17:0];
      s2_kbs   <= s1_coef.kbs;
      s2_krs   <= s1_coef.krs;
    end
  end

  // Stage 3: period, and the boost product.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_period <= s2_pprod[23:18];
      s3_b      <= s2_a * s2_kbs;
      s3_krs    <= s2_krs;
    end
  end

  // Stage 4: scale by the dosing multiplier.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_period <= s3_period;
      s4_c      <= s3_b * dosing_multiplier;
      s4_krs    <= s3_krs;
    end
  end

  // Stage 5: scale by the period and drop the power-of-two part of the divisor.
  assign s5_prod = s4_c * s4_period;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_period <= s4_period;
      s5_pp     <= s5_prod[41:12];
      s5_krs    <= s4_krs;
    end
  end

  // Stage 6: quotient estimate by reciprocal, at most one low.
  assign s6_prod = s5_pp * PumpRecip;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_period <= s5_period;
      s6_pp     <= s5_pp;
      s6_qe     <= s6_prod[49:40];
      s6_krs    <= s5_krs;
    end
  end

  // Stage 7: remainder of the estimate.
  assign s7_qd   = s6_qe * PumpDiv;
  assign s7_diff = s6_pp - s7_qd[29:0];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_period <= s6_period;
      s7_qe     <= s6_qe;
      s7_r      <= s7_diff[21:0];
      s7_krs    <= s6_krs;
    end
  end

  // Stage 8: correct the quotient and clamp it to the period.
  assign s8_q = {1'b0, s7_qe} + {10'd0, (s7_r >= {1'b0, PumpDiv})};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_period <= s7_period;
      s8_pump   <= (s8_q > {5'd0, s7_period}) ? s7_period : s8_q[5:0];
      s8_krs    <= s7_krs;
    end
  end

  // Stage 9: nebulizer numerator.
  assign s9_factor = NebBase + s8_krs;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_period <= s8_period;
      s9_pump   <= s8_pump;
      s9_nx     <= s8_pump * s9_factor;
    end
  end

  // Stage 10: divide by 2000 and hold the result for the consumer.
  assign s10_prod = s9_nx[16:4] * NebRecip;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_period <= s9_period;
      s10_pump   <= s9_pump;
      s10_neb    <= s10_prod[25:20];
    end
  end

  assign period_seconds    = s10_period;
  assign pump_seconds      = s10_pump;
  assign nebulizer_seconds = s10_neb;

`ifndef SYNTH
  // A ready consumer lets the whole pipeline move.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // The pump never runs longer than the period.
  a_pump_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pump_seconds <= period_seconds))
    else $error("pump time exceeds period");

  // The period stays within its coefficient limits.
  a_period_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (period_seconds >= 6'd15 && period_seconds <= 6'd45))
    else $error("period out of range");

  // The nebulizer factor never exceeds one.
  a_neb_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nebulizer_seconds <= pump_seconds))
    else $error("nebulizer time exceeds pump time");

  // A full stage that cannot move keeps its request.
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !en[4]) |=> (vld[4] && $stable(s5_pp)))
    else $error("stalled stage lost its request");
`endif

endmodule
